/* sv/crc32t_pkg.sv */
// Shared types and constants of the MSB-first table-driven CRC-32 engine.
`default_nettype none

package crc32t_pkg;

	// Data path widths
	localparam int CRC_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int BIT_CNT_W = 3;

	// Register map and reset values
	localparam int APB_AW                 = 3;
	localparam logic [CRC_W-1:0] POLY_RST = 32'h04C11DB7;
	localparam logic REG_POLY_SEL         = 1'b0;

	// Action codes carried on the input tuser
	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_DATA   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	// Result status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Table write port driven by the builder
	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [CRC_W-1:0]  data;
	} tbl_wr_t;

endpackage

`default_nettype wire

/* sv/crc32t_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crc32t_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/crc32t_tbl_build.sv */
// Byte table builder: one shared shift/xor step per cycle, eight steps per entry.
`default_nettype none

module crc32t_tbl_build (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [crc32t_pkg::CRC_W-1:0]  poly,
	output crc32t_pkg::tbl_wr_t                tbl_wr,
	output logic                               done
);

	logic                                  busy_q;
	logic [crc32t_pkg::CRC_W-1:0]          poly_q;
	logic [crc32t_pkg::CRC_W-1:0]          v_q;
	logic [crc32t_pkg::TBL_AW-1:0]         idx_q;
	logic [crc32t_pkg::BIT_CNT_W-1:0]      bit_q;
	logic [crc32t_pkg::CRC_W-1:0]          step;
	logic                                  last_bit;
	logic                                  last_idx;
	logic [crc32t_pkg::TBL_AW-1:0]         idx_nxt;

	// shared unit: one polynomial division step
	always_comb begin
		step = {v_q[crc32t_pkg::CRC_W-2:0], 1'b0};
		if (v_q[crc32t_pkg::CRC_W-1]) begin
			step = step ^ poly_q;
		end
	end

	assign last_bit = (bit_q == {crc32t_pkg::BIT_CNT_W{1'b1}});
	assign last_idx = (idx_q == {crc32t_pkg::TBL_AW{1'b1}});
	assign idx_nxt  = idx_q + {{(crc32t_pkg::TBL_AW-1){1'b0}}, 1'b1};

	// entry is complete after the eighth step
	assign tbl_wr.en   = busy_q && last_bit;
	assign tbl_wr.addr = idx_q;
	assign tbl_wr.data = step;
	assign done        = busy_q && last_bit && last_idx;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			bit_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			bit_q  <= '0;
		end else if (busy_q) begin
			bit_q <= bit_q + {{(crc32t_pkg::BIT_CNT_W-1){1'b0}}, 1'b1};
			if (last_bit) begin
				idx_q <= idx_nxt;
				if (last_idx) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// working value and sampled polynomial
	always_ff @(posedge clk) begin
		if (go) begin
			poly_q <= poly;
			v_q    <= '0;
		end else if (busy_q) begin
			if (last_bit) begin
				v_q <= {idx_nxt, {(crc32t_pkg::CRC_W-crc32t_pkg::TBL_AW){1'b0}}};
			end else begin
				v_q <= step;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/crc32_msb_first_table_engine.sv */
// Start: the builder fills 256 entries x 8 shift/xor steps before the result beat.
// Data byte: table RAM read, fold, then output load; finish or refused item: straight to the output load.
// One item at a time; the next item is taken once the result is in the output register.
// Reset clears the session, running CRC and output valid; polynomial resets to 0x04C11DB7.
// Table RAM contents are undefined until the first start builds them; there is no clearing pass.
// Top level: control sequencer, running CRC, byte table and APB register.
`default_nettype none

module crc32_msb_first_table_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [crc32t_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] data_byte
	input  wire logic [1:0]                        s_tuser,  // [1:0] action
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [crc32t_pkg::CRC_W-1:0]           m_tdata,  // [31:0] digest
	output logic                                   m_tuser,  // [0] status
	// APB register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [crc32t_pkg::APB_AW-1:0]     paddr,
	input  wire logic [crc32t_pkg::CRC_W-1:0]      pwdata,
	output logic      [crc32t_pkg::CRC_W-1:0]      prdata,
	output logic                                   pready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BUILD = 4'b0010,
		ST_READ  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                             state_q;
	logic                               open_q;
	logic [crc32t_pkg::CRC_W-1:0]       crc_q;
	logic [crc32t_pkg::CRC_W-1:0]       poly_q;
	logic                               res_status_q;
	logic [crc32t_pkg::CRC_W-1:0]       res_digest_q;
	logic                               m_tvalid_q;
	logic [crc32t_pkg::CRC_W-1:0]       m_tdata_q;
	logic                               m_tuser_q;

	logic                               accept;
	logic                               out_free;
	logic                               build_go;
	logic                               build_done;
	crc32t_pkg::tbl_wr_t                tbl_wr;
	logic                               rd_en;
	logic [crc32t_pkg::TBL_AW-1:0]      rd_addr;
	logic [crc32t_pkg::CRC_W-1:0]       rd_data;
	logic                               reg_wr;

	// APB register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready
		&& (paddr[crc32t_pkg::APB_AW-1] == crc32t_pkg::REG_POLY_SEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crc32t_pkg::POLY_RST;
		end else if (reg_wr) begin
			poly_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[crc32t_pkg::APB_AW-1] == crc32t_pkg::REG_POLY_SEL) begin
			prdata = poly_q;
		end
	end

	// handshakes and table access requests
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign build_go = accept && (s_tuser == crc32t_pkg::ACT_START) && !open_q;
	assign rd_en    = accept && (s_tuser == crc32t_pkg::ACT_DATA) && open_q;
	assign rd_addr  = crc_q[crc32t_pkg::CRC_W-1 -: crc32t_pkg::TBL_AW] ^ s_tdata;

	crc32t_tbl_build u_build (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (build_go),
		.poly   (poly_q),
		.tbl_wr (tbl_wr),
		.done   (build_done)
	);

	crc32t_ram #(
		.WIDTH (crc32t_pkg::CRC_W),
		.DEPTH (crc32t_pkg::TBL_DEPTH)
	) u_tbl (
		.clk     (clk),
		.wr_en   (tbl_wr.en),
		.wr_addr (tbl_wr.addr),
		.wr_data (tbl_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// control sequencer, session and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q  <= 1'b0;
			crc_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (build_go) begin
							state_q <= ST_BUILD;
						end else if (rd_en) begin
							state_q <= ST_READ;
						end else begin
							if ((s_tuser == crc32t_pkg::ACT_FINISH) && open_q) begin
								open_q <= 1'b0;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_BUILD: begin
					if (build_done) begin
						crc_q   <= '0;
						open_q  <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					crc_q   <= {crc_q[crc32t_pkg::CRC_W-crc32t_pkg::BYTE_W-1:0],
						{crc32t_pkg::BYTE_W{1'b0}}} ^ rd_data;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result held until the output register frees
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= crc32t_pkg::STATUS_ERR;
			res_digest_q <= '0;
			if ((s_tuser == crc32t_pkg::ACT_FINISH) && open_q) begin
				res_status_q <= crc32t_pkg::STATUS_OK;
				res_digest_q <= crc_q;
			end
		end else if ((state_q == ST_BUILD && build_done) || state_q == ST_READ) begin
			res_status_q <= crc32t_pkg::STATUS_OK;
			res_digest_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= res_digest_q;
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// table writes only come from a build in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (state_q == ST_BUILD))
		else $error("table written outside of a build");

	// a table lookup is always followed by the fold state
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == ST_READ))
		else $error("table read not followed by fold");

	// a finished build opens the session with a cleared CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD && build_done) |=> (open_q && crc_q == '0))
		else $error("build done without open session");

	// a new result beat only leaves from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat without completed item");

endmodule

`default_nettype wire
